// ===== rtl/tsi_pkg.sv =====
package tsi_pkg;

    // result field width, fixed by the output channel
    localparam int OUT_WIDTH = 16;

    // sequencer states of the top level
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SCAN,
        ST_HOLD
    } tsi_state_t;

    // status of the task scan back to the sequencer
    typedef struct packed {
        logic done;
        logic hit;
    } tsi_scan_status_t;

endpackage

// ===== rtl/tsi_divider.sv =====
module tsi_divider #(
    parameter int WIDTH = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic             done,
    output logic [WIDTH-1:0] quotient,
    output logic [WIDTH-1:0] remainder
);

    localparam int CW = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic [WIDTH:0]   shifted;
    logic [WIDTH:0]   trial;
    logic             fits;

    // one restoring step: bring in the next dividend bit, try the subtract
    always_comb begin
        shifted  = {rem_reg, quo_reg[WIDTH-1]};
        trial    = shifted - {1'b0, divisor};
        fits     = !trial[WIDTH];
        rem_next = fits ? trial[WIDTH-1:0] : shifted[WIDTH-1:0];
        quo_next = {quo_reg[WIDTH-2:0], fits};
    end

    // control: bit counter and busy flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(WIDTH);
        end else if (busy_reg) begin
            if (cnt_reg == '0) begin
                busy_reg <= 1'b0;
            end else begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // quotient shifts in from the right as the dividend shifts out the left
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end else if (busy_reg && cnt_reg != '0) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done      = busy_reg && (cnt_reg == '0);
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/tsi_scan.sv =====
module tsi_scan #(
    parameter int TILE_BITS   = 16,
    parameter int EXTENT_BITS = 20,
    parameter int POS_BITS    = 21
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [TILE_BITS-1:0]      consumer,
    input  logic [TILE_BITS-1:0]      producer,
    input  logic [EXTENT_BITS-1:0]    extent,
    input  logic [TILE_BITS-1:0]      rem_step,
    output tsi_pkg::tsi_scan_status_t status
);

    import tsi_pkg::*;

    logic [TILE_BITS-1:0] r_reg;
    logic [TILE_BITS-1:0] r_next;
    logic [POS_BITS-1:0]  pos_reg;
    logic                 active_reg;
    logic                 hit_reg;
    logic [TILE_BITS:0]   sum;
    logic [TILE_BITS:0]   wrap;
    logic                 carry;
    logic                 task_hit;
    logic                 more;
    logic                 stop;

    // task step: remainder of m*c mod p advances by c mod p
    always_comb begin
        sum      = {1'b0, r_reg} + {1'b0, rem_step};
        wrap     = sum - {1'b0, producer};
        carry    = sum >= {1'b0, producer};
        r_next   = carry ? wrap[TILE_BITS-1:0] : sum[TILE_BITS-1:0];
        // a task straddles one extra tile when the end crosses a boundary unaligned
        task_hit = carry && (r_next != '0);
        // pattern repeats once the remainder returns to zero; extent caps it too
        more     = (r_next != '0) && (pos_reg < POS_BITS'(extent));
        stop     = task_hit || !more;
    end

    // scan state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            hit_reg    <= 1'b0;
        end else if (start) begin
            active_reg <= 1'b1;
            hit_reg    <= 1'b0;
        end else if (active_reg) begin
            hit_reg <= hit_reg | task_hit;
            if (stop) begin
                active_reg <= 1'b0;
            end
        end
    end

    // remainder and start of the next task
    always_ff @(posedge aclk) begin
        if (start) begin
            r_reg   <= '0;
            pos_reg <= POS_BITS'(consumer);
        end else if (active_reg) begin
            r_reg   <= r_next;
            pos_reg <= pos_reg + POS_BITS'(consumer);
        end
    end

    assign status.done = active_reg && stop;
    assign status.hit  = hit_reg | task_hit;

endmodule

// ===== rtl/tile_straddle_inflation_unit.sv =====
// channel | ports                                                        | accepted when
// input   | s_valid s_ready s_consumer_width s_producer_width s_axis_extent | s_valid && s_ready
// result  | m_valid m_ready m_inflation m_worst_wait                     | m_valid && m_ready
//
// one item at a time; a zero operand writes a zero result into the result register on accept
// otherwise bit-serial division c / p, then a scan of the tasks one by one
// (at most min(ceil(e/c), p/gcd(c,p)) tasks, stopping at the first inflated task), then the
// result register is loaded from the quotient, remainder and scan outcome
// reset is synchronous and clears control only; no clearing pass
// a waiting result sits in the result register; the next item is taken once it moves to the output register
module tile_straddle_inflation_unit #(
    parameter int TILE_BITS   = 16,
    parameter int EXTENT_BITS = 20
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [TILE_BITS-1:0]   s_consumer_width,
    input  logic [TILE_BITS-1:0]   s_producer_width,
    input  logic [EXTENT_BITS-1:0] s_axis_extent,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_inflation,
    output logic [15:0]            m_worst_wait
);

    import tsi_pkg::*;

    localparam int POS_BITS = ((EXTENT_BITS > TILE_BITS) ? EXTENT_BITS : TILE_BITS) + 1;
    localparam int EXT_W    = TILE_BITS + OUT_WIDTH + 1;

    tsi_state_t state_reg, state_next;

    logic [TILE_BITS-1:0]   c_reg;
    logic [TILE_BITS-1:0]   p_reg;
    logic [EXTENT_BITS-1:0] e_reg;
    logic [OUT_WIDTH-1:0]   res_worst_reg;
    logic                   res_infl_reg;
    logic [OUT_WIDTH-1:0]   out_worst_reg;
    logic                   out_infl_reg;
    logic                   m_valid_reg;

    logic                   s_fire;
    logic                   degen;
    logic                   out_free;
    logic                   div_start;
    logic                   div_done;
    logic [TILE_BITS-1:0]   div_quo;
    logic [TILE_BITS-1:0]   div_rem;
    logic                   scan_start;
    logic                   res_load;
    logic                   out_load;
    tsi_scan_status_t       scan_status;
    logic [TILE_BITS:0]     worst_full;
    logic [EXT_W-1:0]       worst_ext;
    logic [OUT_WIDTH-1:0]   worst_sat;

    assign s_fire   = s_valid && s_ready;
    assign degen    = (s_consumer_width == '0) || (s_producer_width == '0)
                   || (s_axis_extent == '0);
    assign out_free = !m_valid_reg || m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = degen ? ST_HOLD : ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_status.done) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_ready    = 1'b0;
        div_start  = 1'b0;
        scan_start = 1'b0;
        res_load   = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                div_start = s_valid && !degen;
            end
            ST_DIV:  scan_start = div_done;
            ST_SCAN: res_load = scan_status.done;
            ST_HOLD: out_load = out_free;
            default: s_ready = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // operand capture
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            c_reg <= s_consumer_width;
            p_reg <= s_producer_width;
            e_reg <= s_axis_extent;
        end
    end

    // c / p, one quotient bit per cycle
    tsi_divider #(
        .WIDTH (TILE_BITS)
    ) u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (s_consumer_width),
        .divisor   (p_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // walk the tasks of one period
    tsi_scan #(
        .TILE_BITS   (TILE_BITS),
        .EXTENT_BITS (EXTENT_BITS),
        .POS_BITS    (POS_BITS)
    ) u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (scan_start),
        .consumer (c_reg),
        .producer (p_reg),
        .extent   (e_reg),
        .rem_step (div_rem),
        .status   (scan_status)
    );

    // worst = ceil(c/p) plus one if any task straddles an extra tile, saturated to OUT_WIDTH bits
    always_comb begin
        worst_full = {1'b0, div_quo} + (TILE_BITS + 1)'(div_rem != '0)
                   + (TILE_BITS + 1)'(scan_status.hit);
        worst_ext  = EXT_W'(worst_full);
        worst_sat  = (worst_ext > EXT_W'({OUT_WIDTH{1'b1}})) ? {OUT_WIDTH{1'b1}}
                                                            : worst_ext[OUT_WIDTH-1:0];
    end

    // finished result, waiting for the output register
    always_ff @(posedge aclk) begin
        if (s_fire && degen) begin
            res_worst_reg <= '0;
            res_infl_reg  <= 1'b0;
        end else if (res_load) begin
            res_worst_reg <= worst_sat;
            res_infl_reg  <= scan_status.hit;
        end
    end

    // output beat register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_worst_reg <= res_worst_reg;
            out_infl_reg  <= res_infl_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_inflation  = out_infl_reg;
    assign m_worst_wait = out_worst_reg;

    // an inflated result always waits on at least two tiles
    a_infl_worst: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_inflation) |-> (m_worst_wait > OUT_WIDTH'(1)))
        else $error("inflated result with worst wait below two");

    // divider remainder stays below the producer width during the scan
    a_rem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (div_rem < p_reg))
        else $error("divider remainder out of range");

    // scan only finishes while the sequencer is scanning
    a_scan_state: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_status.done |-> (state_reg == ST_SCAN))
        else $error("scan finished outside scan state");

    // no new beat is taken right after one is accepted
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !s_ready)
        else $error("input accepted while an item is in flight");

endmodule
